[rtl/brle_pkg.sv]
package brle_pkg;

    // Largest extra-repeat count that fits in one count byte
    localparam logic [7:0] COUNT_MAX = 8'd255;

    // Depth of the result queue between the encoder and the output port
    localparam int unsigned RESULT_DEPTH = 4;

    // One encoded result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_count;
        logic       last_of_item;
        logic       stream_end;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

endpackage

[rtl/byte_run_length_encoder.sv]
// Run-length encoder for a byte stream with a double-byte escape. Bytes pass
// through as literals until two equal literals follow each other; further
// copies are swallowed and counted (up to 255), and the count byte, flagged by
// m_is_count, is sent when a different byte arrives, the count is full, or the
// stream ends (s_final_byte). An input item yields zero, one or two result
// items; m_last_of_item marks the last one of each input and m_stream_end the
// last one of the stream, after which the encoder is back in its reset state.
// The encoder takes one input item per cycle whenever its four-entry result
// queue has room for two items; the output port drains one item per cycle
// while m_ready is high, so the sustained rate is one input per cycle as long
// as inputs average at most one result, and one result per cycle otherwise.
// Results are registered in the result queue before reaching the output port.
module byte_run_length_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_count,
    output logic       m_last_of_item,
    output logic       m_stream_end
);

    logic [7:0] prev_byte_reg;
    logic [7:0] prev_byte_next;
    logic       pair_armed_reg;
    logic       pair_armed_next;
    logic       in_run_reg;
    logic       in_run_next;
    logic [7:0] run_count_reg;
    logic [7:0] run_count_next;

    logic              accept;
    logic              hit;
    logic [1:0]        res_num;
    logic [1:0]        push_num;
    brle_pkg::result_t res0;
    brle_pkg::result_t res1;
    brle_pkg::result_t out_item;
    logic              room2;

    assign s_ready = room2;
    assign accept  = s_valid && s_ready;
    assign hit     = (s_data_byte == prev_byte_reg);

    // Encode one item against the run state
    always_comb begin
        prev_byte_next  = prev_byte_reg;
        pair_armed_next = pair_armed_reg;
        in_run_next     = in_run_reg;
        run_count_next  = run_count_reg;
        res0            = '0;
        res1            = '0;
        res_num         = 2'd0;

        if (in_run_reg) begin
            if (hit && (run_count_reg != brle_pkg::COUNT_MAX)) begin
                // Swallow the repeat; report the count only at end of stream
                run_count_next = run_count_reg + 8'd1;
                res0.out_byte  = run_count_reg + 8'd1;
                res0.is_count  = 1'b1;
                res_num        = s_final_byte ? 2'd1 : 2'd0;
            end else begin
                // Close the run, then send the breaking byte as a literal
                res0.out_byte   = run_count_reg;
                res0.is_count   = 1'b1;
                res1.out_byte   = s_data_byte;
                res1.is_count   = 1'b0;
                res_num         = 2'd2;
                in_run_next     = 1'b0;
                run_count_next  = '0;
                prev_byte_next  = s_data_byte;
                pair_armed_next = 1'b1;
            end
        end else begin
            res0.out_byte = s_data_byte;
            res0.is_count = 1'b0;
            if (pair_armed_reg && hit) begin
                // Second of a pair: start counting
                in_run_next     = 1'b1;
                run_count_next  = '0;
                pair_armed_next = 1'b0;
                res1.out_byte   = '0;
                res1.is_count   = 1'b1;
                res_num         = s_final_byte ? 2'd2 : 2'd1;
            end else begin
                prev_byte_next  = s_data_byte;
                pair_armed_next = 1'b1;
                res_num         = 2'd1;
            end
        end

        // Mark the last result of the item and of the stream
        res0.last_of_item = (res_num == 2'd1);
        res0.stream_end   = s_final_byte && (res_num == 2'd1);
        res1.last_of_item = 1'b1;
        res1.stream_end   = s_final_byte;

        // Drop back to the start state after the final byte
        if (s_final_byte) begin
            prev_byte_next  = '0;
            pair_armed_next = 1'b0;
            in_run_next     = 1'b0;
            run_count_next  = '0;
        end
    end

    assign push_num = accept ? res_num : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_byte_reg  <= '0;
            pair_armed_reg <= 1'b0;
            in_run_reg     <= 1'b0;
            run_count_reg  <= '0;
        end else if (accept) begin
            prev_byte_reg  <= prev_byte_next;
            pair_armed_reg <= pair_armed_next;
            in_run_reg     <= in_run_next;
            run_count_reg  <= run_count_next;
        end
    end

    // Queue results toward the output port
    brle_result_fifo #(
        .DEPTH (brle_pkg::RESULT_DEPTH)
    ) u_result_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_num   (push_num),
        .wr_data0 (res0),
        .wr_data1 (res1),
        .wr_room2 (room2),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_data  (out_item)
    );

    assign m_out_byte     = out_item.out_byte;
    assign m_is_count     = out_item.is_count;
    assign m_last_of_item = out_item.last_of_item;
    assign m_stream_end   = out_item.stream_end;

endmodule

[rtl/brle_result_fifo.sv]
module brle_result_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Write side: up to two items per cycle, first item in wr_data0
    input  logic [1:0]              wr_num,
    input  brle_pkg::result_t       wr_data0,
    input  brle_pkg::result_t       wr_data1,
    output logic                    wr_room2,
    // Read side
    output logic                    rd_valid,
    input  logic                    rd_ready,
    output brle_pkg::result_t       rd_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

    brle_pkg::result_t  mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      wr_ptr_next;
    logic [PW-1:0]      wr_ptr_plus1;
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW-1:0]      rd_ptr_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == LAST_IDX) ? '0 : p + PW'(1);
    endfunction

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;
    assign wr_room2 = (count_reg <= ROOM_LIMIT);

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
        unique case (wr_num)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            default: wr_ptr_next = ptr_inc(wr_ptr_plus1);
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(wr_num) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store written items
    always_ff @(posedge aclk) begin
        if (wr_num != 2'd0) begin
            mem_reg[wr_ptr_reg] <= wr_data0;
        end
        if (wr_num == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= wr_data1;
        end
    end

endmodule
